### hw/rtl/ezq_pkg.sv
// Package: shared types and constants for the Euler ZYX to quaternion core.
package ezq_pkg;

	localparam int XY_WIDTH = 32;
	localparam int Z_WIDTH  = 34;

	typedef logic signed [XY_WIDTH-1:0] xy_t;
	typedef logic signed [Z_WIDTH-1:0]  zres_t;
	typedef logic signed [63:0]         q60_t;

	localparam xy_t CORDIC_GAIN = xy_t'(652032874);

	// arctan(2^-i), pi = 2^31
	function automatic zres_t atan_step(input int unsigned i);
		zres_t r;
		case (i)
			0:  r = zres_t'(536870912);
			1:  r = zres_t'(316933406);
			2:  r = zres_t'(167458907);
			3:  r = zres_t'(85004756);
			4:  r = zres_t'(42667331);
			5:  r = zres_t'(21354465);
			6:  r = zres_t'(10679838);
			7:  r = zres_t'(5340245);
			8:  r = zres_t'(2670163);
			9:  r = zres_t'(1335087);
			10: r = zres_t'(667544);
			11: r = zres_t'(333772);
			12: r = zres_t'(166886);
			13: r = zres_t'(83443);
			14: r = zres_t'(41722);
			15: r = zres_t'(20861);
			16: r = zres_t'(10430);
			17: r = zres_t'(5215);
			18: r = zres_t'(2608);
			19: r = zres_t'(1304);
			20: r = zres_t'(652);
			21: r = zres_t'(326);
			22: r = zres_t'(163);
			23: r = zres_t'(81);
			24: r = zres_t'(41);
			25: r = zres_t'(20);
			26: r = zres_t'(10);
			27: r = zres_t'(5);
			28: r = zres_t'(3);
			29: r = zres_t'(1);
			30: r = zres_t'(1);
			default: r = zres_t'(0);
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/ezq_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of half a binary angle.
module ezq_cordic #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                     clk,
	input  logic [CORDIC_STAGES-1:0] en,
	input  logic [ANGLE_WIDTH-1:0]   angle,
	output ezq_pkg::xy_t             sin_v,
	output ezq_pkg::xy_t             cos_v
);

	ezq_pkg::xy_t   x_s [CORDIC_STAGES];
	ezq_pkg::xy_t   y_s [CORDIC_STAGES];
	ezq_pkg::zres_t z_s [CORDIC_STAGES];
	ezq_pkg::zres_t a_ext;
	ezq_pkg::zres_t z_in;

	assign a_ext = ezq_pkg::zres_t'($signed(angle));

	generate
		if (ANGLE_WIDTH <= 31) begin : g_scale
			assign z_in = a_ext <<< (31 - ANGLE_WIDTH);
		end else begin : g_half
			assign z_in = a_ext >>> 1;
		end
	endgenerate

	genvar i;
	generate
		for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
			ezq_pkg::xy_t   xp;
			ezq_pkg::xy_t   yp;
			ezq_pkg::zres_t zp;
			if (i == 0) begin : g_first
				assign xp = ezq_pkg::CORDIC_GAIN;
				assign yp = '0;
				assign zp = z_in;
			end else begin : g_next
				assign xp = x_s[i-1];
				assign yp = y_s[i-1];
				assign zp = z_s[i-1];
			end
			always_ff @(posedge clk) begin
				if (en[i]) begin
					if (!zp[ezq_pkg::Z_WIDTH-1]) begin
						x_s[i] <= xp - (yp >>> i);
						y_s[i] <= yp + (xp >>> i);
						z_s[i] <= zp - ezq_pkg::atan_step(i);
					end else begin
						x_s[i] <= xp + (yp >>> i);
						y_s[i] <= yp - (xp >>> i);
						z_s[i] <= zp + ezq_pkg::atan_step(i);
					end
				end
			end
		end
	endgenerate

	assign sin_v = y_s[CORDIC_STAGES-1];
	assign cos_v = x_s[CORDIC_STAGES-1];

endmodule

### hw/rtl/euler_zyx_to_quaternion_core.sv
// Top level: Z-Y-X Euler angles to unit quaternion, streaming pipeline.
// Pipeline: the CORDIC stages, then pair products, triple products and rounding.
// Throughput: one transaction per cycle unless m_tready stalls it; a stage advances
// when empty or when the next stage advances, so bubbles collapse under backpressure.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module euler_zyx_to_quaternion_core #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int QUAT_WIDTH    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// roll_angle, pitch_angle, yaw_angle, zero pad
	input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// quat_w, quat_x, quat_y, quat_z, zero pad
	output logic [((4*QUAT_WIDTH+7)/8)*8-1:0]  m_tdata
);

	localparam int DEPTH   = CORDIC_STAGES + 3;
	localparam int FRAC    = QUAT_WIDTH - 2;
	localparam int OUT_W   = ((4*QUAT_WIDTH+7)/8)*8;
	localparam int SUM_W   = 66;

	logic [DEPTH-1:0] v_q;
	logic [DEPTH-1:0] en;

	always_comb begin
		en[DEPTH-1] = !v_q[DEPTH-1] || m_tready;
		for (int k = DEPTH-2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= s_tvalid;
			for (int k = 1; k < DEPTH; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	ezq_pkg::xy_t sr, cr, sp, cp, sy, cy;

	ezq_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en[CORDIC_STAGES-1:0]),
		.angle(s_tdata[ANGLE_WIDTH-1:0]), .sin_v(sr), .cos_v(cr));
	ezq_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en[CORDIC_STAGES-1:0]),
		.angle(s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]), .sin_v(sp), .cos_v(cp));
	ezq_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en[CORDIC_STAGES-1:0]),
		.angle(s_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]), .sin_v(sy), .cos_v(cy));

	// pair products, rounded to Q30
	function automatic ezq_pkg::xy_t mul_q30(input ezq_pkg::xy_t a, input ezq_pkg::xy_t b);
		ezq_pkg::q60_t p;
		p = (64'(a) * 64'(b)) + (64'sd1 <<< 29);
		return p[61:30];
	endfunction

	ezq_pkg::xy_t crcp_s1, srsp_s1, srcp_s1, crsp_s1, cy_s1, sy_s1;

	always_ff @(posedge clk) begin
		if (en[CORDIC_STAGES]) begin
			crcp_s1 <= mul_q30(cr, cp);
			srsp_s1 <= mul_q30(sr, sp);
			srcp_s1 <= mul_q30(sr, cp);
			crsp_s1 <= mul_q30(cr, sp);
			cy_s1   <= cy;
			sy_s1   <= sy;
		end
	end

	ezq_pkg::q60_t t_w0_s2, t_w1_s2, t_x0_s2, t_x1_s2;
	ezq_pkg::q60_t t_y0_s2, t_y1_s2, t_z0_s2, t_z1_s2;

	always_ff @(posedge clk) begin
		if (en[CORDIC_STAGES+1]) begin
			t_w0_s2 <= 64'(crcp_s1) * 64'(cy_s1);
			t_w1_s2 <= 64'(srsp_s1) * 64'(sy_s1);
			t_x0_s2 <= 64'(srcp_s1) * 64'(cy_s1);
			t_x1_s2 <= 64'(crsp_s1) * 64'(sy_s1);
			t_y0_s2 <= 64'(crsp_s1) * 64'(cy_s1);
			t_y1_s2 <= 64'(srcp_s1) * 64'(sy_s1);
			t_z0_s2 <= 64'(crcp_s1) * 64'(sy_s1);
			t_z1_s2 <= 64'(srsp_s1) * 64'(cy_s1);
		end
	end

	function automatic logic [QUAT_WIDTH-1:0] to_quat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] one;
		logic signed [SUM_W-1:0] res;
		one = SUM_W'(1) <<< FRAC;
		r = (s + (SUM_W'(1) <<< (59 - FRAC))) >>> (60 - FRAC);
		if (r > one) res = one;
		else if (r < -one) res = -one;
		else res = r;
		return res[QUAT_WIDTH-1:0];
	endfunction

	logic [QUAT_WIDTH-1:0] qw_s3, qx_s3, qy_s3, qz_s3;

	always_ff @(posedge clk) begin
		if (en[DEPTH-1]) begin
			qw_s3 <= to_quat(SUM_W'(t_w0_s2) + SUM_W'(t_w1_s2));
			qx_s3 <= to_quat(SUM_W'(t_x0_s2) - SUM_W'(t_x1_s2));
			qy_s3 <= to_quat(SUM_W'(t_y0_s2) + SUM_W'(t_y1_s2));
			qz_s3 <= to_quat(SUM_W'(t_z0_s2) - SUM_W'(t_z1_s2));
		end
	end

	assign m_tdata = OUT_W'({qz_s3, qy_s3, qx_s3, qw_s3});

endmodule

### hw/rtl/ezq_checker.sv
// Checker: port-level properties of the quaternion core, bound to the top level.
module ezq_checker #(
	parameter int QUAT_WIDTH = 16,
	parameter int OUT_W      = 64
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam logic signed [QUAT_WIDTH-1:0] ONE = QUAT_WIDTH'(1) <<< (QUAT_WIDTH - 2);

	logic signed [QUAT_WIDTH-1:0] qw;
	assign qw = m_tdata[QUAT_WIDTH-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with output ready");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (qw <= ONE) && (qw >= -ONE))
		else $error("quat_w out of unit range");

endmodule

bind euler_zyx_to_quaternion_core ezq_checker #(
	.QUAT_WIDTH(QUAT_WIDTH),
	.OUT_W(((4*QUAT_WIDTH+7)/8)*8)
) u_ezq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

### test/tb.sv
// Testbench for euler_zyx_to_quaternion_core: random and directed angle triples.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = 16;
	localparam int QW = 16;
	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [QW-1:0] z;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] w;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;

	quat_t pending_quats[$];
	int mismatches = 0;
	int checked = 0;
	int sent = 0;
	int cycles = 0;
	bit saw_sat = 0;

	euler_zyx_to_quaternion_core #(
		.ANGLE_WIDTH(AW), .QUAT_WIDTH(QW), .CORDIC_STAGES(STAGES)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	task automatic half_sin_cos(input logic [AW-1:0] ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'($signed(ang)) * (longint'(1) << (31 - AW));
		for (int i = 0; i < STAGES; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ezq_pkg::atan_step(i));
			end else begin
				x += dx; y -= dy; z += longint'(ezq_pkg::atan_step(i));
			end
		end
		s = y;
		c = x;
	endtask

	function automatic longint prod3(longint a, longint b, longint c);
		return floor_shr(a * b + (longint'(1) << 29), 30) * c;
	endfunction

	function automatic logic [QW-1:0] round_q60(longint q, ref bit sat);
		longint one, r;
		one = longint'(1) << (QW - 2);
		r = floor_shr(q + (longint'(1) << (59 - (QW - 2))), 60 - (QW - 2));
		if (r > one) begin
			r = one; sat = 1;
		end
		if (r < -one) begin
			r = -one; sat = 1;
		end
		return r[QW-1:0];
	endfunction

	task automatic predict_quat(input logic [AW-1:0] r, p, yw, output quat_t q);
		longint sr, cr, sp, cp, sy, cy;
		half_sin_cos(r, sr, cr);
		half_sin_cos(p, sp, cp);
		half_sin_cos(yw, sy, cy);
		q.w = round_q60(prod3(cr, cp, cy) + prod3(sr, sp, sy), saw_sat);
		q.x = round_q60(prod3(sr, cp, cy) - prod3(cr, sp, sy), saw_sat);
		q.y = round_q60(prod3(cr, sp, cy) + prod3(sr, cp, sy), saw_sat);
		q.z = round_q60(prod3(cr, cp, sy) - prod3(sr, sp, cy), saw_sat);
	endtask

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	bit no_gaps = 0;

	task automatic send_angles(input logic [AW-1:0] r, p, yw);
		quat_t q;
		int g;
		predict_quat(r, p, yw, q);
		g = no_gaps ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {yw, p, r};
		pending_quats = {pending_quats, q};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic idle_sender();
		s_tvalid <= 1'b0;
	endtask

	// receiver: stalls at random, checks each transaction
	always @(posedge clk) begin
		quat_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output %h", m_tdata);
			end else begin
				want = pending_quats.pop_front();
				checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: w/x/y/z exp %0d %0d %0d %0d %s %0d %0d %0d %0d",
							checked, want.w, want.x, want.y, want.z, "got",
							got.w, got.x, got.y, got.z);
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (no_gaps) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left <= gap_len();
			m_tready <= 1'b1;
		end
	end

	task automatic drain_quats();
		idle_sender();
		while (pending_quats.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [AW-1:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000, 16'hc000};
		foreach (ext[i]) send_angles(ext[i], 16'h0, 16'h0);
		foreach (ext[i]) send_angles(16'h0, ext[i], 16'h0);
		foreach (ext[i]) send_angles(16'h0, 16'h0, ext[i]);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h7fff, 16'h7fff, 16'h7fff);
		send_angles(16'h5555, 16'haaaa, 16'h0001);
		send_angles(16'haaaa, 16'h5555, 16'hfffe);
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) drain_quats();	// sender holds until all outputs are back
			if (i >= n / 4 && i < n / 4 + 60) no_gaps = 1;
			else no_gaps = 0;
			send_angles(AW'($urandom()), AW'($urandom()), AW'($urandom()));
		end
		no_gaps = 0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(930);
		drain_quats();
		repeat (LATENCY + 5) @(posedge clk);
		$display("%0d angle triples sent, %0d quaternions checked, saturation seen: %0d",
			sent, checked, saw_sat);
		$display("covered angle extremes, random angles, stalls on both sides and a full drain");
		if (mismatches == 0 && pending_quats.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d outputs missing", mismatches, pending_quats.size());
			$display("simulation failed");
		end
		$finish;
	end
endmodule
